// ----- hw/rtl/tmua_pkg.sv -----
// Shared constants, types and the controller state enum of the timed multi-unit allocator.
// Depends on nothing; every other file of the block but tmua_ram imports it.
`default_nettype none

package tmua_pkg;

  localparam int unsigned MAX_UNITS  = 128;
  localparam int unsigned TIME_WIDTH = 20;

  localparam int unsigned END_W  = TIME_WIDTH + 1;
  localparam int unsigned IDX_W  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_UNITS + 1);
  localparam int unsigned WANT_W = 8;
  localparam int unsigned HOLD_W = 10;
  localparam int unsigned ACT_W  = 8;
  localparam int unsigned SUM_W  = 14;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(128);

  // register index carried in paddr[2]
  localparam logic [0:0] REG_ACTIVE_UNITS = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL,
    ST_CHECK,
    ST_ALLOC,
    ST_DONE
  } tmua_state_e;

  typedef struct packed {
    logic load;
    logic rel_step;
    logic alloc_init;
    logic alloc_step;
    logic publish;
  } tmua_cmd_t;

  typedef struct packed {
    logic rel_done;
    logic enough;
    logic alloc_done;
    logic out_free;
  } tmua_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tmua_req_if.sv -----
// Request channel: valid/ready handshake with arrival time, units wanted and hold time.
// Depends on tmua_pkg for field widths.
`default_nettype none

interface tmua_req_if import tmua_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] arrival_time;
  logic [WANT_W-1:0]     units_wanted;
  logic [HOLD_W-1:0]     hold_time;

  modport source (output valid, output arrival_time, output units_wanted,
                  output hold_time, input ready);
  modport sink   (input valid, input arrival_time, input units_wanted,
                  input hold_time, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmua_rsp_if.sv -----
// Result channel: valid/ready handshake with grant flag and unit number sum.
// Depends on tmua_pkg for field widths.
`default_nettype none

interface tmua_rsp_if import tmua_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [SUM_W-1:0] unit_sum;

  modport source (output valid, output granted, output unit_sum, input ready);
  modport sink   (input valid, input granted, input unit_sum, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/timed_multi_unit_allocator.sv -----
// Top level of the timed multi-unit allocator: APB register, controller and datapath.
// Depends on tmua_pkg, tmua_req_if, tmua_rsp_if, tmua_ctrl and tmua_dp.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        arrival_time[19:0] units_wanted[7:0] hold_time[9:0]
//   rsp_o    out  valid/ready        granted unit_sum[13:0]
//   apb      in   psel/penable/pwrite  paddr[2:0] pwdata[31:0], read on prdata
//
// An item passes through accept, release scan, decision, allocation scan and result in that
// order; the allocation scan ends once the last wanted unit is granted, and it is skipped
// when the item is rejected.
// The release scan reads the end-time RAM one unit per cycle; the allocation scan walks the
// busy bits one unit per cycle. The result waits in ST_DONE while the output register is full and not being read.
// The next item is taken once the previous result sits in the output register.
// Reset frees every unit and sets active_units to 128; no clearing pass is needed.
`default_nettype none

module timed_multi_unit_allocator import tmua_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  tmua_req_if.sink                req_i,
  tmua_rsp_if.source              rsp_o
);

  logic [ACT_W-1:0] active_q;
  logic [CNT_W-1:0] lim;
  logic             cfg_wr;
  tmua_cmd_t        cmd;
  tmua_sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_UNITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_q <= pwdata[ACT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_UNITS) ? PDATA_W'(active_q) : '0;

  // clamp the unit count to the pool size
  assign lim = (32'(active_q) > 32'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : CNT_W'(active_q);

  tmua_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tmua_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .lim_i          (lim),
    .arrival_time_i (req_i.arrival_time),
    .units_wanted_i (req_i.units_wanted),
    .hold_time_i    (req_i.hold_time),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_granted_o  (rsp_o.granted),
    .rsp_unit_sum_o (rsp_o.unit_sum)
  );

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> cmd.rel_step)
    else $error("accepted item did not start the release scan");

  a_publish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> sts.out_free)
    else $error("result written over a pending result");

  a_alloc_only_if_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.alloc_step |-> sts.enough)
    else $error("allocation scan running for a request that does not fit");

  a_reject_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.granted |-> rsp_o.unit_sum == '0)
    else $error("rejected item carries a nonzero unit sum");

endmodule

`default_nettype wire

// ----- hw/rtl/tmua_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the per-unit end times.
`default_nettype none

module tmua_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmua_ctrl.sv -----
// Sequencing state machine: accept, release scan, decision, allocation scan, result.
// Depends on tmua_pkg for the state enum and the command/status structs.
`default_nettype none

module tmua_ctrl import tmua_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire tmua_sts_t sts_i,
  output tmua_cmd_t      cmd_o
);

  tmua_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REL;
        end
      end
      ST_REL: begin
        cmd_o.rel_step = 1'b1;
        if (sts_i.rel_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.alloc_init = 1'b1;
        state_d          = sts_i.enough ? ST_ALLOC : ST_DONE;
      end
      ST_ALLOC: begin
        if (sts_i.alloc_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.alloc_step = 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmua_dp.sv -----
// Datapath: busy bits, end-time RAM, scan counter, free count, sum and result register.
// Depends on tmua_pkg and tmua_ram.
`default_nettype none

module tmua_dp import tmua_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tmua_cmd_t             cmd_i,
  output tmua_sts_t                  sts_o,
  input  wire logic [CNT_W-1:0]      lim_i,
  input  wire logic [TIME_WIDTH-1:0] arrival_time_i,
  input  wire logic [WANT_W-1:0]     units_wanted_i,
  input  wire logic [HOLD_W-1:0]     hold_time_i,
  output logic                       rsp_valid_o,
  input  wire logic                  rsp_ready_i,
  output logic                       rsp_granted_o,
  output logic [SUM_W-1:0]           rsp_unit_sum_o
);

  logic [MAX_UNITS-1:0]  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      free_q, free_d;
  logic                  out_v_q, out_v_d;

  logic [TIME_WIDTH-1:0] now_q;
  logic [END_W-1:0]      end_q;
  logic [WANT_W-1:0]     want_q;
  logic [WANT_W-1:0]     left_q, left_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic                  grant_q;
  logic                  out_granted_q;
  logic [SUM_W-1:0]      out_sum_q;

  logic [IDX_W-1:0]      p_idx;
  logic [IDX_W-1:0]      a_idx;
  logic [END_W-1:0]      ram_rdata;
  logic                  ram_we;
  logic                  expired;

  // read address runs one ahead of the unit being checked
  tmua_ram #(
    .WIDTH (END_W),
    .DEPTH (MAX_UNITS)
  ) u_end_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (a_idx),
    .wdata_i (end_q),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign p_idx   = IDX_W'(cnt_q - CNT_W'(1));
  assign a_idx   = cnt_q[IDX_W-1:0];
  assign expired = busy_q[p_idx] && (ram_rdata <= END_W'(now_q));

  assign sts_o.rel_done   = (cnt_q == CNT_W'(MAX_UNITS));
  assign sts_o.enough     = (32'(free_q) >= 32'(want_q));
  assign sts_o.alloc_done = (left_q == '0) || (cnt_q >= lim_i);
  assign sts_o.out_free   = !out_v_q || rsp_ready_i;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    free_d  = free_q;
    left_d  = left_q;
    sum_d   = sum_q;
    ram_we  = 1'b0;
    out_v_d = out_v_q;

    if (cmd_i.load) begin
      cnt_d  = '0;
      free_d = '0;
    end

    if (cmd_i.rel_step) begin
      if (cnt_q != '0) begin
        if (expired) begin
          busy_d[p_idx] = 1'b0;
        end
        if ((CNT_W'(p_idx) < lim_i) && (!busy_q[p_idx] || expired)) begin
          free_d = free_q + CNT_W'(1);
        end
      end
      if (cnt_q != CNT_W'(MAX_UNITS)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end

    if (cmd_i.alloc_init) begin
      cnt_d  = '0;
      left_d = want_q;
      sum_d  = '0;
    end

    if (cmd_i.alloc_step) begin
      if ((cnt_q < lim_i) && (left_q != '0) && !busy_q[a_idx]) begin
        busy_d[a_idx] = 1'b1;
        ram_we        = 1'b1;
        sum_d         = sum_q + SUM_W'(32'(cnt_q) + 32'd1);
        left_d        = left_q - WANT_W'(1);
      end
      cnt_d = cnt_q + CNT_W'(1);
    end

    if (cmd_i.publish) begin
      out_v_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      cnt_q   <= '0;
      free_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      free_q  <= free_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    sum_q  <= sum_d;
    if (cmd_i.load) begin
      now_q  <= arrival_time_i;
      end_q  <= END_W'(arrival_time_i) + END_W'(hold_time_i);
      want_q <= units_wanted_i;
    end
    if (cmd_i.alloc_init) begin
      grant_q <= sts_o.enough;
    end
    if (cmd_i.publish) begin
      out_granted_q <= grant_q;
      out_sum_q     <= sum_q;
    end
  end

  assign rsp_valid_o    = out_v_q;
  assign rsp_granted_o  = out_granted_q;
  assign rsp_unit_sum_o = out_sum_q;

endmodule

`default_nettype wire

// ----- test/timed_multi_unit_allocator_tb.sv -----
// Self-checking testbench for the timed multi-unit allocator: request driver, result monitor,
// APB register writes and an in-bench prediction of which units each request is granted.
// Depends on tmua_pkg, tmua_req_if, tmua_rsp_if and the timed_multi_unit_allocator RTL.
`timescale 1ns / 100ps

module timed_multi_unit_allocator_tb import tmua_pkg::*; ();

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned LONG_HOLD_OFF = 3000;
  localparam int unsigned DRAIN_CYCLES  = 2 * MAX_UNITS + 16;
  localparam int unsigned TIME_MAX      = (1 << TIME_WIDTH) - 1;

  localparam logic [PADDR_W-1:0] ACTIVE_ADDR = {REG_ACTIVE_UNITS, 2'b00};

  typedef struct packed {
    logic [TIME_WIDTH-1:0] arrival;
    logic [WANT_W-1:0]     want;
    logic [HOLD_W-1:0]     hold;
  } request_t;

  typedef struct packed {
    logic             granted;
    logic [SUM_W-1:0] sum;
  } grant_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tmua_req_if req_if ();
  tmua_rsp_if rsp_if ();

  timed_multi_unit_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  // Unit pool as the block should see it.
  logic             unit_held    [MAX_UNITS];
  logic [END_W-1:0] unit_free_at [MAX_UNITS];
  logic [ACT_W-1:0] units_active = ACTIVE_RESET;

  request_t    requests_to_send [$];
  grant_t      grants_due       [$];
  request_t    next_req;
  grant_t      oldest_grant;
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;
  int unsigned rsp_wait  = 0;
  int unsigned rsp_calm  = 0;
  int unsigned rsp_stall;
  int unsigned req_time  = 0;
  int unsigned cycle_count = 0;
  int          n_errors   = 0;
  int          n_results  = 0;
  int          n_granted  = 0;
  int          n_rejected = 0;

  always begin
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
  end

  // Release expired units, then take the lowest free ones within the active range, or reject when too few are free.
  function automatic grant_t allocate_units(request_t r);
    int unsigned in_service;
    int unsigned n_free;
    int unsigned left;
    int unsigned total;
    int unsigned u;
    grant_t      g;
    g = '0;
    in_service = (units_active > MAX_UNITS) ? MAX_UNITS : units_active;
    for (u = 0; u < MAX_UNITS; u++)
      if (unit_held[u] && unit_free_at[u] <= END_W'(r.arrival)) unit_held[u] = 1'b0;
    n_free = 0;
    for (u = 0; u < in_service; u++)
      if (!unit_held[u]) n_free++;
    if (n_free < r.want) return g;
    left  = r.want;
    total = 0;
    for (u = 0; u < in_service && left != 0; u++) begin
      if (!unit_held[u]) begin
        unit_held[u]    = 1'b1;
        unit_free_at[u] = END_W'(r.arrival) + END_W'(r.hold);
        total += u + 1;
        left--;
      end
    end
    g.granted = 1'b1;
    g.sum     = SUM_W'(total);
    return g;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run of back-to-back items.
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      calm = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(24, 4);
    return $urandom_range(300, 25);
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (req_if.valid && req_if.ready)
      grants_due.push_back(allocate_units({req_if.arrival_time, req_if.units_wanted,
                                           req_if.hold_time}));
    if (!req_if.valid || req_if.ready) begin
      if (send_gap != 0) begin
        send_gap     <= send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (requests_to_send.size() != 0) begin
        next_req = requests_to_send.pop_front();
        req_if.arrival_time <= next_req.arrival;
        req_if.units_wanted <= next_req.want;
        req_if.hold_time    <= next_req.hold;
        req_if.valid        <= 1'b1;
        send_gap            <= next_gap(send_calm);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      if (grants_due.size() == 0) begin
        $display("%0t: result with nothing outstanding: granted %0b unit_sum %0d",
                 $time, rsp_if.granted, rsp_if.unit_sum);
        n_errors++;
      end else begin
        oldest_grant = grants_due.pop_front();
        if (rsp_if.granted !== oldest_grant.granted) begin
          $display("%0t: granted mismatch: expected %0b, got %0b",
                   $time, oldest_grant.granted, rsp_if.granted);
          n_errors++;
        end
        if (rsp_if.unit_sum !== oldest_grant.sum) begin
          $display("%0t: unit_sum mismatch: expected %0d, got %0d",
                   $time, oldest_grant.sum, rsp_if.unit_sum);
          n_errors++;
        end
      end
      n_results++;
      if (rsp_if.granted === 1'b1) n_granted++;
      else n_rejected++;
      // hold off long enough for the block to back up into its input
      if (n_results == 150 || n_results == 400) rsp_stall = LONG_HOLD_OFF;
      else rsp_stall = next_gap(rsp_calm);
      rsp_if.ready <= (rsp_stall == 0);
      rsp_wait     <= rsp_stall;
    end else begin
      if (rsp_wait != 0) rsp_wait <= rsp_wait - 1;
      rsp_if.ready <= (rsp_wait <= 1);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               grants_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_request(int unsigned arrival, int unsigned want, int unsigned hold);
    request_t r;
    r.arrival = TIME_WIDTH'(arrival);
    r.want    = WANT_W'(want);
    r.hold    = HOLD_W'(hold);
    requests_to_send.push_back(r);
  endtask

  task automatic wait_for_grants();
    while (requests_to_send.size() != 0 || req_if.valid || grants_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic check_active_readback();
    logic [PDATA_W-1:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ACTIVE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    readback = prdata;
    if (readback[ACT_W-1:0] !== units_active) begin
      $display("%0t: active_units readback mismatch: expected %0d, got %0d",
               $time, units_active, readback[ACT_W-1:0]);
      n_errors++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits carry noise; only the low byte lands in the register.
  task automatic program_active(logic [ACT_W-1:0] count);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[ACT_W-1:0] = count;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    units_active = count;
    check_active_readback();
  endtask

  // Mostly rising times with small wants; some equal or earlier times, empty and oversized wants.
  task automatic queue_traffic(int unsigned n_items, int unsigned max_want,
                               int unsigned max_step, int unsigned max_jump);
    int unsigned roll;
    int unsigned arrival;
    int unsigned want;
    int unsigned hold;
    int unsigned back;
    req_time += $urandom_range(max_jump);
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        back    = $urandom_range(40);
        arrival = (req_time > back) ? req_time - back : 0;
      end else begin
        if (roll >= 8) req_time += $urandom_range(max_step, 1);
        arrival = req_time;
      end
      roll = $urandom_range(99);
      if (roll < 5) want = 0;
      else if (roll < 10) want = $urandom_range(255, 129);
      else if (roll < 78) want = $urandom_range((max_want < 8) ? max_want : 8, 1);
      else want = $urandom_range(max_want, 1);
      roll = $urandom_range(99);
      if (roll < 10) hold = 0;
      else if (roll < 20) hold = (1 << HOLD_W) - 1;
      else hold = $urandom_range((1 << HOLD_W) - 1, 1);
      add_request(arrival, want, hold);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_if.valid = 1'b0;
    req_if.arrival_time = '0;
    req_if.units_wanted = '0;
    req_if.hold_time    = '0;
    rsp_if.ready = 1'b1;
    for (int u = 0; u < MAX_UNITS; u++) begin
      unit_held[u]    = 1'b0;
      unit_free_at[u] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_active_readback();

    // full pool: zero hold, zero want, whole pool, exhaustion, equal and earlier times
    add_request(0, 1, 0);
    add_request(0, 0, 0);
    add_request(1, 1, 5);
    add_request(3, 128, 1023);
    add_request(6, 128, 10);
    add_request(10, 1, 1);
    add_request(15, 1, 1);
    add_request(16, 2, 0);
    add_request(16, 1, 3);
    add_request(12, 255, 1023);
    add_request(20, 129, 512);
    add_request(21, 127, 1023);
    add_request(22, 1, 1);
    add_request(23, 1, 1);
    add_request(1044, 2, 682);
    add_request(1045, 85, 341);
    req_time = 1045;
    wait_for_grants();

    program_active(ACT_W'(128));
    queue_traffic(150, 32, 40, 0);
    wait_for_grants();

    // shrink while most units are still held
    program_active(ACT_W'(1));
    queue_traffic(40, 3, 200, 0);
    wait_for_grants();

    program_active(ACT_W'(0));
    add_request(req_time + 1, 1, 1);
    add_request(req_time + 2, 0, 1);
    req_time += 2;
    queue_traffic(12, 2, 20, 0);
    wait_for_grants();

    program_active(ACT_W'(255));
    queue_traffic(100, 128, 60, 60000);
    wait_for_grants();

    program_active(ACT_W'(37));
    queue_traffic(100, 16, 30, 60000);
    wait_for_grants();

    program_active(ACT_W'(5));
    queue_traffic(50, 5, 80, 0);
    wait_for_grants();

    program_active(ACT_W'(128));
    queue_traffic(100, 40, 25, 60000);
    wait_for_grants();

    // top of the time range, end times spill into the extra bit
    for (int i = 0; i < 8; i++)
      add_request(TIME_MAX - 35 + 5 * i, $urandom_range(20, 1), 1023);
    wait_for_grants();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests checked (%0d granted, %0d rejected)", n_results, n_granted,
             n_rejected);
    $display("active units 0, 1, 5, 37, 128 and 255 with readback; two long result stalls");
    if (n_errors == 0 && grants_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, grants_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
